### sv/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// widths of the discriminant, square root and divider datapaths
// ----------------------------------------------------------------------------
`default_nettype none

package qrs_pkg;

  localparam int COEF_W    = 16;                      // coefficient width
  localparam int FRAC_BITS = 16;                      // fraction bits of results
  localparam int OUT_W     = 40;                      // result width
  localparam int PROD_W    = 2 * COEF_W;              // b*b and a*c
  localparam int D_W       = 2 * COEF_W + 3;          // signed discriminant
  localparam int MAG_W     = 2 * COEF_W + 2;          // |d|, even width
  localparam int SQ_STEPS  = (MAG_W + 2 * FRAC_BITS) / 2;
  localparam int ROOT_W    = SQ_STEPS;
  localparam int REM_W     = ROOT_W + 4;
  localparam int NB_W      = COEF_W + FRAC_BITS + 1;  // -b * 2^F
  localparam int NUM_W     = ROOT_W + 1;              // numerator magnitude
  localparam int NSUM_W    = NUM_W + 1;               // signed numerator
  localparam int DEN_SW    = COEF_W + 2;              // signed 2a or b
  localparam int DEN_W     = COEF_W + 1;              // divisor magnitude
  localparam int DIV_STEPS = NUM_W;
  localparam int PIPE_DEPTH = SQ_STEPS + DIV_STEPS + 4;

  typedef enum logic [2:0] {
    CASE_TWO_REAL = 3'd0,
    CASE_DOUBLE   = 3'd1,
    CASE_COMPLEX  = 3'd2,
    CASE_LINEAR   = 3'd3,
    CASE_IDENTITY = 3'd4,
    CASE_CONTRA   = 3'd5
  } case_code_t;

  typedef struct packed {
    case_code_t               code;
    logic signed [DEN_SW-1:0] den;
    logic signed [NB_W-1:0]   nb;
  } meta_t;

  typedef struct packed {
    logic              valid;
    meta_t             meta;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [MAG_W-1:0]  rad;
  } sq_lane_t;

  typedef struct packed {
    case_code_t code;
    logic       sgn1;
    logic       sgn2;
  } dmeta_t;

  typedef struct packed {
    logic             valid;
    dmeta_t           meta;
    logic [DEN_W-1:0] dm;
    logic [DEN_W-1:0] r1;
    logic [NUM_W-1:0] n1;
    logic [DEN_W-1:0] r2;
    logic [NUM_W-1:0] n2;
  } dv_lane_t;

endpackage

`default_nettype wire

### sv/qrs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// qrs_sqrt_cell: one digit step of the square root chain
// retires two radicand bits and produces one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_sqrt_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qrs_pkg::sq_lane_t lane_i,
  output qrs_pkg::sq_lane_t      lane_o
);
  import qrs_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             take;
  sq_lane_t         lane_nxt;
  sq_lane_t         lane_r;

  always_comb begin
    rem_sh   = {lane_i.rem[REM_W-3:0], lane_i.rad[MAG_W-1 -: 2]};
    trial    = REM_W'({lane_i.root, 2'b01});
    take     = (rem_sh >= trial);
    lane_nxt = lane_i;
    lane_nxt.rem  = take ? (rem_sh - trial) : rem_sh;
    lane_nxt.root = {lane_i.root[ROOT_W-2:0], take};
    lane_nxt.rad  = {lane_i.rad[MAG_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r.valid <= lane_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_r.meta <= lane_nxt.meta;
    lane_r.rem  <= lane_nxt.rem;
    lane_r.root <= lane_nxt.root;
    lane_r.rad  <= lane_nxt.rad;
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

### sv/qrs_div_cell.sv
// ----------------------------------------------------------------------------
// qrs_div_cell: one restoring step of the divider chain
// two numerator lanes share one divisor, one quotient bit each per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module qrs_div_cell (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire qrs_pkg::dv_lane_t lane_i,
  output qrs_pkg::dv_lane_t      lane_o
);
  import qrs_pkg::*;

  logic [DEN_W:0] t1;
  logic [DEN_W:0] t2;
  logic [DEN_W:0] dm_x;
  logic           q1;
  logic           q2;
  logic [DEN_W:0] d1;
  logic [DEN_W:0] d2;
  dv_lane_t       lane_nxt;
  dv_lane_t       lane_r;

  always_comb begin
    dm_x = {1'b0, lane_i.dm};
    t1   = {lane_i.r1, lane_i.n1[NUM_W-1]};
    t2   = {lane_i.r2, lane_i.n2[NUM_W-1]};
    q1   = (t1 >= dm_x);
    q2   = (t2 >= dm_x);
    d1   = t1 - dm_x;
    d2   = t2 - dm_x;
    lane_nxt    = lane_i;
    lane_nxt.r1 = q1 ? d1[DEN_W-1:0] : t1[DEN_W-1:0];
    lane_nxt.r2 = q2 ? d2[DEN_W-1:0] : t2[DEN_W-1:0];
    lane_nxt.n1 = {lane_i.n1[NUM_W-2:0], q1};
    lane_nxt.n2 = {lane_i.n2[NUM_W-2:0], q2};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lane_r.valid <= 1'b0;
    end else begin
      lane_r.valid <= lane_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_r.meta <= lane_nxt.meta;
    lane_r.dm   <= lane_nxt.dm;
    lane_r.r1   <= lane_nxt.r1;
    lane_r.n1   <= lane_nxt.n1;
    lane_r.r2   <= lane_nxt.r2;
    lane_r.n2   <= lane_nxt.n2;
  end

  assign lane_o = lane_r;

endmodule

`default_nettype wire

### sv/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver: roots of a*x^2 + b*x + c = 0 in Q24.16
// discriminant, square root chain and divider chain, fully pipelined
// ----------------------------------------------------------------------------
// A new coefficient set is taken in every clock cycle (busy stays low) and
// its result leaves the output register marked by out_valid for one
// cycle. The receiver cannot stall, so results must be taken as they come.
// The latency is set by the 33-cell square root chain (one root bit per
// cell) and the 34-cell divider chain (one quotient bit per cell), plus two
// discriminant stages, one numerator setup stage and the output register.
`default_nettype none

module quadratic_root_solver (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [qrs_pkg::COEF_W-1:0]  in_coef_a,
  input  wire logic signed [qrs_pkg::COEF_W-1:0]  in_coef_b,
  input  wire logic signed [qrs_pkg::COEF_W-1:0]  in_coef_c,
  output logic                                    out_valid,
  output qrs_pkg::case_code_t                     out_case_code,
  output logic signed [qrs_pkg::OUT_W-1:0]        out_first_value,
  output logic signed [qrs_pkg::OUT_W-1:0]        out_second_value
);
  import qrs_pkg::*;

  // stage 1: products
  logic                     p1_valid_r;
  logic signed [COEF_W-1:0] p1_a_r, p1_b_r, p1_c_r;
  logic signed [PROD_W-1:0] p1_bb_r, p1_ac_r;

  // stage 2: discriminant, case and chain entry
  logic signed [D_W-1:0]    d;
  logic                     a_zero;
  logic signed [NB_W-1:0]   nb;
  logic signed [DEN_SW-1:0] den;
  case_code_t               code;
  sq_lane_t                 sq_nxt;
  sq_lane_t                 sq_bus [0:SQ_STEPS];

  // numerator setup
  sq_lane_t                 sq_end;
  logic signed [NSUM_W-1:0] s_x, nb_x, n1, n2;
  logic                     den_neg;
  dv_lane_t                 dv_nxt;
  dv_lane_t                 dv_bus [0:DIV_STEPS];

  // output
  dv_lane_t                 dv_end;
  logic signed [OUT_W-1:0]  q1_x, q2_x;
  logic signed [OUT_W-1:0]  v1_nxt, v2_nxt;
  logic                     out_valid_r;
  case_code_t               out_code_r;
  logic signed [OUT_W-1:0]  out_v1_r, out_v2_r;

  // the pipeline never stalls
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
    end else begin
      p1_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    p1_a_r  <= in_coef_a;
    p1_b_r  <= in_coef_b;
    p1_c_r  <= in_coef_c;
    p1_bb_r <= in_coef_b * in_coef_b;
    p1_ac_r <= in_coef_a * in_coef_c;
  end

  // d = b*b - 4*a*c, classify, and load the square root chain with |d|
  always_comb begin
    d      = D_W'(p1_bb_r) - (D_W'(p1_ac_r) <<< 2);
    a_zero = (p1_a_r == '0);
    // linear case reuses the same numerator slot for -c * 2^F
    nb     = -(NB_W'(a_zero ? p1_c_r : p1_b_r) <<< FRAC_BITS);
    den    = a_zero ? DEN_SW'(p1_b_r) : (DEN_SW'(p1_a_r) <<< 1);
    if (a_zero) begin
      if (p1_b_r != '0) begin
        code = CASE_LINEAR;
      end else if (p1_c_r == '0) begin
        code = CASE_IDENTITY;
      end else begin
        code = CASE_CONTRA;
      end
    end else if (d > 0) begin
      code = CASE_TWO_REAL;
    end else if (d == 0) begin
      code = CASE_DOUBLE;
    end else begin
      code = CASE_COMPLEX;
    end
    sq_nxt.valid     = p1_valid_r;
    sq_nxt.meta.code = code;
    sq_nxt.meta.den  = den;
    sq_nxt.meta.nb   = nb;
    sq_nxt.rem       = '0;
    sq_nxt.root      = '0;
    sq_nxt.rad       = MAG_W'((d < 0) ? -d : d);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_bus[0].valid <= 1'b0;
    end else begin
      sq_bus[0].valid <= sq_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    sq_bus[0].meta <= sq_nxt.meta;
    sq_bus[0].rem  <= sq_nxt.rem;
    sq_bus[0].root <= sq_nxt.root;
    sq_bus[0].rad  <= sq_nxt.rad;
  end

  // square root chain: s = floor(sqrt(|d| * 2^(2F)))
  for (genvar gi = 0; gi < SQ_STEPS; gi++) begin : g_sqrt
    qrs_sqrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (sq_bus[gi]),
      .lane_o (sq_bus[gi+1])
    );
  end

  // pick the two numerators and the divisor for the case
  always_comb begin
    sq_end  = sq_bus[SQ_STEPS];
    s_x     = $signed(NSUM_W'(sq_end.root));
    nb_x    = NSUM_W'(sq_end.meta.nb);
    den_neg = sq_end.meta.den[DEN_SW-1];
    case (sq_end.meta.code)
      CASE_TWO_REAL: begin
        n1 = nb_x - s_x;
        n2 = nb_x + s_x;
      end
      CASE_DOUBLE: begin
        n1 = nb_x;
        n2 = nb_x;
      end
      CASE_COMPLEX: begin
        n1 = nb_x;
        n2 = s_x;
      end
      CASE_LINEAR: begin
        n1 = nb_x;
        n2 = '0;
      end
      default: begin
        n1 = '0;
        n2 = '0;
      end
    endcase
    dv_nxt.valid     = sq_end.valid;
    dv_nxt.meta.code = sq_end.meta.code;
    // truncation toward zero: divide magnitudes, sign applied at the end
    dv_nxt.meta.sgn1 = n1[NSUM_W-1] ^ den_neg;
    dv_nxt.meta.sgn2 = n2[NSUM_W-1] ^ den_neg;
    // zero divisor only in identity and contradiction, whose numerators are 0
    if (sq_end.meta.den == '0) begin
      dv_nxt.dm = DEN_W'(1);
    end else begin
      dv_nxt.dm = DEN_W'(den_neg ? -sq_end.meta.den : sq_end.meta.den);
    end
    dv_nxt.r1 = '0;
    dv_nxt.n1 = NUM_W'(n1[NSUM_W-1] ? -n1 : n1);
    dv_nxt.r2 = '0;
    dv_nxt.n2 = NUM_W'(n2[NSUM_W-1] ? -n2 : n2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_bus[0].valid <= 1'b0;
    end else begin
      dv_bus[0].valid <= dv_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    dv_bus[0].meta <= dv_nxt.meta;
    dv_bus[0].dm   <= dv_nxt.dm;
    dv_bus[0].r1   <= dv_nxt.r1;
    dv_bus[0].n1   <= dv_nxt.n1;
    dv_bus[0].r2   <= dv_nxt.r2;
    dv_bus[0].n2   <= dv_nxt.n2;
  end

  // divider chain: both quotients share the divisor
  for (genvar gj = 0; gj < DIV_STEPS; gj++) begin : g_div
    qrs_div_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .lane_i (dv_bus[gj]),
      .lane_o (dv_bus[gj+1])
    );
  end

  // apply signs; magnitudes stay well inside the 40-bit range
  always_comb begin
    dv_end = dv_bus[DIV_STEPS];
    q1_x   = $signed(OUT_W'(dv_end.n1));
    q2_x   = $signed(OUT_W'(dv_end.n2));
    v1_nxt = dv_end.meta.sgn1 ? -q1_x : q1_x;
    v2_nxt = dv_end.meta.sgn2 ? -q2_x : q2_x;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_code_r <= dv_end.meta.code;
    out_v1_r   <= v1_nxt;
    out_v2_r   <= v2_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_case_code    = out_code_r;
  assign out_first_value  = out_v1_r;
  assign out_second_value = out_v2_r;

  // every result comes from a transfer a fixed number of cycles earlier
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && rst_n, PIPE_DEPTH))
    else $error("result without matching input transfer");

  // degenerate equations give zero values
  a_degenerate_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_case_code == CASE_IDENTITY || out_case_code == CASE_CONTRA)
    |-> (out_first_value == '0) && (out_second_value == '0))
    else $error("nonzero value for identity or contradiction");

  // a double root reports the same value twice
  a_double_equal : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_case_code == CASE_DOUBLE) |-> out_first_value == out_second_value)
    else $error("double root values differ");

  // linear case has no second value
  a_linear_second : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_case_code == CASE_LINEAR) |-> out_second_value == '0)
    else $error("linear case with nonzero second value");

endmodule

`default_nettype wire

### sim/tb_quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver: self-checking bench of the quadratic root solver
// predicts case code and both Q24.16 values for each coefficient transfer and
// compares every strobed result in order, with random idle bursts on input
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_quadratic_root_solver;
  import qrs_pkg::*;

  typedef struct {
    case_code_t     code;
    logic [OUT_W-1:0] first;
    logic [OUT_W-1:0] second;
  } root_set_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [COEF_W-1:0] in_coef_a, in_coef_b, in_coef_c;
  logic out_valid;
  case_code_t out_case_code;
  logic signed [OUT_W-1:0] out_first_value, out_second_value;

  root_set_t pending_roots[$];
  int  n_errors;
  bit  idle_bursts;

  quadratic_root_solver u_dut (
    .clk, .rst_n, .start, .busy,
    .in_coef_a, .in_coef_b, .in_coef_c,
    .out_valid, .out_case_code, .out_first_value, .out_second_value
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // generous limit for all items, their idle bursts and the pipeline drain
  initial begin
    #400000;
    $display("FAIL quadratic_root_solver");
    $finish;
  end

  // floor(sqrt(v)) by the bit-by-bit method, 128-bit wide
  function automatic logic [63:0] isqrt(logic [127:0] v);
    logic [127:0] rem, trial;
    logic [63:0] root;
    rem  = '0;
    root = '0;
    for (int k = 63; k >= 0; k--) begin
      rem   = (rem << 2) | ((v >> (2 * k)) & 128'd3);
      trial = ({64'd0, root} << 2) | 128'd1;
      if (rem >= trial) begin
        rem  = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  // clamp to the signed 40-bit range
  function automatic logic [OUT_W-1:0] clamp_q(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (OUT_W - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return v[OUT_W-1:0];
  endfunction

  function automatic root_set_t solve_quadratic(longint a, longint b, longint c);
    root_set_t r;
    longint disc, s, den, nb, v1, v2;
    logic [127:0] mag;
    v1 = 0;
    v2 = 0;
    if (a == 0) begin
      if (b != 0) begin
        r.code = CASE_LINEAR;
        v1 = (-c * (longint'(1) <<< FRAC_BITS)) / b;
      end else begin
        r.code = (c == 0) ? CASE_IDENTITY : CASE_CONTRA;
      end
    end else begin
      disc = b * b - 4 * a * c;
      mag  = (disc < 0) ? 128'(-disc) : 128'(disc);
      s    = longint'(isqrt(mag << (2 * FRAC_BITS)));
      den  = 2 * a;
      nb   = -b * (longint'(1) <<< FRAC_BITS);
      if (disc > 0) begin
        r.code = CASE_TWO_REAL;
        v1 = (nb - s) / den;
        v2 = (nb + s) / den;
      end else if (disc == 0) begin
        r.code = CASE_DOUBLE;
        v1 = nb / den;
        v2 = v1;
      end else begin
        r.code = CASE_COMPLEX;
        v1 = nb / den;
        v2 = s / den;
      end
    end
    r.first  = clamp_q(v1);
    r.second = clamp_q(v2);
    return r;
  endfunction

  // one coefficient transfer, with an optional idle burst before it
  task automatic send_coefs(int a, int b, int c);
    if (idle_bursts && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    start     <= 1'b1;
    in_coef_a <= a[COEF_W-1:0];
    in_coef_b <= b[COEF_W-1:0];
    in_coef_c <= c[COEF_W-1:0];
    do @(posedge clk); while (busy);
    pending_roots.push_back(solve_quadratic(longint'(signed'(a[COEF_W-1:0])),
                                            longint'(signed'(b[COEF_W-1:0])),
                                            longint'(signed'(c[COEF_W-1:0]))));
  endtask

  task automatic stop_sending();
    start <= 1'b0;
  endtask

  // wait until every expected result has come back
  task automatic drain_results();
    stop_sending();
    while (pending_roots.size() != 0) @(posedge clk);
  endtask

  // result checker: every strobe consumes the oldest expectation
  always @(posedge clk) begin
    root_set_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_roots.size() == 0) begin
        $error("result with no expectation waiting");
        n_errors++;
      end else begin
        exp_r = pending_roots.pop_front();
        if (out_case_code !== exp_r.code) begin
          $error("case_code expected %0d actual %0d", exp_r.code, out_case_code);
          n_errors++;
        end
        if (out_first_value !== exp_r.first) begin
          $error("first_value expected %0d actual %0d",
                 $signed(exp_r.first), out_first_value);
          n_errors++;
        end
        if (out_second_value !== exp_r.second) begin
          $error("second_value expected %0d actual %0d",
                 $signed(exp_r.second), out_second_value);
          n_errors++;
        end
      end
    end
  end

  // extremes of the coefficients and every case code
  task automatic test_directed();
    int ext[3] = '{-32768, 32767, 0};
    send_coefs(1, -3, 2);       // two real roots
    send_coefs(1, 2, 1);        // double root
    send_coefs(1, 0, 1);        // complex pair
    send_coefs(-2, 1, -5);      // complex pair, negative a
    send_coefs(0, 3, -7);       // linear
    send_coefs(0, 0, 0);        // identity
    send_coefs(0, 0, 9);        // contradiction
    send_coefs(0, 1, -32768);   // linear, large quotient
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++)
        send_coefs(ext[i], ext[j], ext[(i + j + 1) % 3]);
    send_coefs(-32768, -32768, -32768);
    send_coefs(32767, 32767, 32767);
    send_coefs(-1, -1, -1);
    send_coefs(1, -32768, 1);
  endtask

  // random coefficients with a bias toward each case
  task automatic test_random(int count);
    int a, b, c, k;
    for (int n = 0; n < count; n++) begin
      a = int'($urandom_range(0, 65535)) - 32768;
      b = int'($urandom_range(0, 65535)) - 32768;
      c = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 7))
        0: a = 0;                               // linear family
        1: begin a = 0; b = 0; if ($urandom_range(0, 1)) c = 0; end
        2: begin                                // double root: (k*x + m)^2
          k = int'($urandom_range(1, 181));
          c = int'($urandom_range(0, 181));
          a = k * k;
          b = 2 * k * c;
          c = c * c;
          if (b > 32767) b = 0;
          if ($urandom_range(0, 1)) b = -b;
        end
        3: begin                                // small values
          a = int'($urandom_range(0, 15)) - 8;
          b = int'($urandom_range(0, 15)) - 8;
          c = int'($urandom_range(0, 15)) - 8;
        end
        default: ;
      endcase
      send_coefs(a, b, c);
    end
  endtask

  initial begin
    n_errors    = 0;
    idle_bursts = 1'b0;
    rst_n       = 1'b0;
    start       = 1'b0;
    in_coef_a   = '0;
    in_coef_b   = '0;
    in_coef_c   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idle_bursts = 1'b1;
    test_directed();
    drain_results();            // sender holds off until all results are back
    test_random(900);
    idle_bursts = 1'b0;         // last stretch streams back to back
    test_random(425);
    drain_results();
    repeat (80) @(posedge clk);

    if (n_errors == 0 && pending_roots.size() == 0) begin
      $display("PASS quadratic_root_solver");
    end else begin
      $display("FAIL quadratic_root_solver");
    end
    $finish;
  end

endmodule

### quadratic_root_solver.f
sv/qrs_pkg.sv
sv/qrs_sqrt_cell.sv
sv/qrs_div_cell.sv
sv/quadratic_root_solver.sv
sim/tb_quadratic_root_solver.sv
